FILE: rtl/lcmu_pkg.sv
// lcmu_pkg: shared types and field widths for the least common multiple unit.
// Used by lcmu_core, lcm_unit_top and lcm_unit_top_tb; depends on nothing else.

package lcmu_pkg;

    // Widths of the stream fields
    localparam int unsigned OPERAND_FIELD_W = 16;
    localparam int unsigned RESULT_FIELD_W  = 32;
    localparam int unsigned S_TDATA_W       = 2 * OPERAND_FIELD_W;
    localparam int unsigned M_TDATA_W       = RESULT_FIELD_W;

    // Control from the stream shell to the core
    typedef struct packed {
        logic start;   // operands are valid this cycle, begin a new word
        logic take;    // output register can accept the finished result
    } t_core_ctl;

    // Status from the core to the stream shell
    typedef struct packed {
        logic idle;    // core waits for operands
        logic done;    // result is held and waiting to be taken
    } t_core_stat;

endpackage

FILE: rtl/lcm_unit_top.sv
// lcm_unit_top: stream shell around lcmu_core with an output register.
// Depends on lcmu_pkg and lcmu_core.
//
// Usage:
//   Slave channel carries one word of two operands: first_operand in
//   tdata[15:0], second_operand in tdata[31:16]. Only the low
//   min(OPERAND_WIDTH, 16) bits of each operand are used.
//   Master channel returns one word per input word: lcm_value in tdata[31:0],
//   zero when either operand is zero.
//   Processing: the core does one GCD, divide or multiply step per cycle on
//   the shared add/subtract unit. A zero operand goes straight to done.
//   Throughput: one word at a time; tready is high only while the core idles.
//   A finished result waits in the output register, so the next word is
//   accepted while it waits. If the receiver stalls with the register full,
//   the core holds its result and accepts nothing more.
//   Reset (synchronous, active low) empties the output register and returns
//   the core to idle.

module lcm_unit_top #(
    parameter int unsigned OPERAND_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [15:0] first_operand, [31:16] second_operand
    input  logic [lcmu_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [31:0] lcm_value
    output logic [lcmu_pkg::M_TDATA_W-1:0]    o_m_axis_tdata
);
    import lcmu_pkg::*;

    localparam int unsigned EW = (OPERAND_WIDTH < OPERAND_FIELD_W) ?
                                 OPERAND_WIDTH : OPERAND_FIELD_W;

    t_core_ctl                 core_ctl;
    t_core_stat                core_stat;
    logic [2*EW-1:0]           core_result;
    logic                      r_out_valid;
    logic [M_TDATA_W-1:0]      r_out_data;
    logic                      out_free;

    // Accept operands only while the core idles
    assign o_s_axis_tready = core_stat.idle;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign core_ctl.start  = i_s_axis_tvalid && core_stat.idle;
    assign core_ctl.take   = out_free;

    lcmu_core #(
        .EW (EW)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (core_ctl),
        .i_opa    (i_s_axis_tdata[EW-1:0]),
        .i_opb    (i_s_axis_tdata[OPERAND_FIELD_W+EW-1:OPERAND_FIELD_W]),
        .o_stat   (core_stat),
        .o_result (core_result)
    );

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_stat.done && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_stat.done && out_free) begin
            r_out_data <= M_TDATA_W'(core_result);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

FILE: rtl/lcmu_core.sv
// lcmu_core: sequencer and shared add/subtract unit that computes lcm(a, b).
// Binary GCD, restoring divide a / g, then shift-add multiply by b.
// Depends on lcmu_pkg.

module lcmu_core #(
    parameter int unsigned EW = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lcmu_pkg::t_core_ctl i_ctl,
    input  logic [EW-1:0]       i_opa,
    input  logic [EW-1:0]       i_opb,
    output lcmu_pkg::t_core_stat o_stat,
    output logic [2*EW-1:0]     o_result
);
    import lcmu_pkg::*;

    localparam int unsigned CW = $clog2(EW);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_STRIP = 6'b000010,
        S_GCD   = 6'b000100,
        S_DIV   = 6'b001000,
        S_MUL   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [EW-1:0] r_x, n_x;       // GCD operand a, then remainder, then product high half
    logic [EW-1:0] r_y, n_y;       // GCD operand b, then the divisor g
    logic [EW-1:0] r_lo, n_lo;     // dividend/quotient, then product low half
    logic [EW-1:0] r_opa, n_opa;
    logic [EW-1:0] r_opb, n_opb;
    logic [CW-1:0] r_k, n_k;       // common factors of two stripped
    logic [CW-1:0] r_cnt, n_cnt;   // step counter for divide and multiply

    // Shared add/subtract unit
    logic [EW:0] u_x, u_y, u_sum;
    logic        u_sub;
    logic        u_borrow;

    always_comb begin
        u_x   = '0;
        u_y   = '0;
        u_sub = 1'b1;
        unique case (r_state)
            S_GCD: begin
                u_x = {1'b0, r_x};
                u_y = {1'b0, r_y};
            end
            S_DIV: begin
                u_x = {r_x, r_lo[EW-1]};
                u_y = {1'b0, r_y};
            end
            S_MUL: begin
                u_x   = {1'b0, r_x};
                u_y   = {1'b0, r_opb};
                u_sub = 1'b0;
            end
            default: begin
                u_sub = 1'b1;
            end
        endcase
    end

    assign u_sum    = u_x + (u_sub ? ~u_y : u_y) + {{EW{1'b0}}, u_sub};
    assign u_borrow = u_sum[EW];

    // Sequencer
    always_comb begin
        logic [EW:0] mul_s;
        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_lo    = r_lo;
        n_opa   = r_opa;
        n_opb   = r_opb;
        n_k     = r_k;
        n_cnt   = r_cnt;
        mul_s   = r_lo[0] ? u_sum : {1'b0, r_x};
        unique case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_x   = i_opa;
                    n_y   = i_opb;
                    n_opa = i_opa;
                    n_opb = i_opb;
                    n_k   = '0;
                    if (i_opa == '0 || i_opb == '0) begin
                        // zero operand gives a zero multiple
                        n_x     = '0;
                        n_lo    = '0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_STRIP;
                    end
                end
            end
            S_STRIP: begin
                // drop common factors of two, count them in k
                if (r_x[0] || r_y[0]) begin
                    n_state = S_GCD;
                end else begin
                    n_x = r_x >> 1;
                    n_y = r_y >> 1;
                    n_k = r_k + CW'(1);
                end
            end
            S_GCD: begin
                if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (u_sum[EW-1:0] == '0) begin
                    // equal odd parts: g is that value times 2^k
                    n_y     = r_x << r_k;
                    n_x     = '0;
                    n_lo    = r_opa;
                    n_cnt   = CW'(EW - 1);
                    n_state = S_DIV;
                end else if (u_borrow) begin
                    n_x = r_y;
                    n_y = r_x;
                end else begin
                    n_x = u_sum[EW-1:0] >> 1;
                end
            end
            S_DIV: begin
                // restoring step: one quotient bit per cycle
                n_x   = u_borrow ? u_x[EW-1:0] : u_sum[EW-1:0];
                n_lo  = {r_lo[EW-2:0], ~u_borrow};
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_x     = '0;
                    n_cnt   = CW'(EW - 1);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // shift-add step: add b when the low multiplier bit is set
                n_x   = mul_s[EW:1];
                n_lo  = {mul_s[0], r_lo[EW-1:1]};
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_ctl.take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_lo  <= n_lo;
        r_opa <= n_opa;
        r_opb <= n_opb;
        r_k   <= n_k;
        r_cnt <= n_cnt;
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_DONE);
    assign o_result    = {r_x, r_lo};

    // Checks
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> r_state == S_IDLE)
        else $error("start while core busy");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_y != '0)
        else $error("divide by zero gcd");

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_x < r_y)
        else $error("remainder not below divisor");

    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_ctl.take) |=> r_state == S_DONE)
        else $error("result dropped before taken");

endmodule

FILE: test/lcm_unit_top_tb.sv
// lcm_unit_top_tb: self-checking stream testbench for lcm_unit_top.
// Predicts each least common multiple with Euclid's algorithm and checks every
// output word in order; depends on lcmu_pkg and the lcm_unit_top RTL.

module lcm_unit_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lcmu_pkg::*;

    localparam int unsigned OPERAND_WIDTH = 16;
    localparam logic [63:0] OPERAND_MASK  = (64'd1 << OPERAND_WIDTH) - 64'd1;
    localparam int          RESET_CYCLES  = 9;
    localparam int          IDLE_PCT      = 36;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          QUIET_LIMIT   = 4000;
    localparam int          DRAIN_CYCLES  = 200;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    // [15:0] first_operand, [31:16] second_operand
    logic [S_TDATA_W-1:0]  i_s_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    // [31:0] lcm_value
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;

    logic [RESULT_FIELD_W-1:0] lcm_expected[$];
    int                        mismatch_count = 0;
    int                        quiet_cycles   = 0;
    int                        tx_idle_pct    = 0;
    int                        rx_idle_pct    = 0;
    bit                        rx_hold_req    = 1'b0;

    lcm_unit_top #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Least common multiple of the masked operands, zero if either is zero
    function automatic logic [RESULT_FIELD_W-1:0] predict_lcm(
        input logic [OPERAND_FIELD_W-1:0] first_op,
        input logic [OPERAND_FIELD_W-1:0] second_op
    );
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] r;
        a = 64'(first_op) & OPERAND_MASK;
        b = 64'(second_op) & OPERAND_MASK;
        if (a == 64'd0 || b == 64'd0) begin
            return '0;
        end
        x = a;
        y = b;
        while (y != 64'd0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return RESULT_FIELD_W'((a / x) * b);
    endfunction

    // Record accepted operands, check returned words, count quiet cycles
    always @(posedge i_clk) begin
        logic [RESULT_FIELD_W-1:0] want;
        logic [RESULT_FIELD_W-1:0] pred;
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                pred = predict_lcm(i_s_axis_tdata[15:0], i_s_axis_tdata[31:16]);
                lcm_expected = {lcm_expected, pred};
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (lcm_expected.size() == 0) begin
                    $error("lcm_value: unexpected word, got %0d", o_m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = lcm_expected.pop_front();
                    if (o_m_axis_tdata !== want) begin
                        $error("lcm_value: expected %0d, got %0d", want, o_m_axis_tdata);
                        mismatch_count++;
                    end
                end
            end
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Stop a hung run
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("lcm_unit_top_tb: done, errors");
        $finish;
    end

    // Drive the receiver side; hold off for a long stretch on request
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                i_m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end
            i_m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Offer one operand pair and hold it until it is accepted
    task automatic send_operands(input logic [15:0] first_op, input logic [15:0] second_op);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            i_s_axis_tdata  = $urandom;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {second_op, first_op};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Drop valid and wait for every outstanding word
    task automatic wait_drained();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (lcm_expected.size() != 0) @(posedge i_clk);
    endtask

    // Draw an operand pair from a mix of shapes that stress the GCD loop
    task automatic pick_operands(output logic [15:0] first_op, output logic [15:0] second_op);
        int unsigned shape;
        int unsigned factor;
        logic [15:0] tmp;
        shape = $urandom_range(9);
        case (shape) inside
            0: begin
                first_op  = 16'd0;
                second_op = 16'($urandom);
            end
            1, 2, 3: begin
                first_op  = 16'($urandom);
                second_op = 16'($urandom);
            end
            4, 5: begin
                factor    = $urandom_range(1, 4096);
                first_op  = 16'(factor * $urandom_range(0, 65535 / factor));
                second_op = 16'(factor * $urandom_range(0, 65535 / factor));
            end
            6: begin
                first_op  = 16'($urandom_range(1, 65535) << $urandom_range(0, 15));
                second_op = 16'($urandom_range(1, 65535) << $urandom_range(0, 15));
            end
            7: begin
                first_op  = 16'($urandom);
                second_op = first_op;
            end
            8: begin
                first_op  = 16'($urandom_range(0, 31));
                second_op = 16'($urandom_range(0, 31));
            end
            default: begin
                first_op  = 16'(65535 - $urandom_range(0, 15));
                second_op = 16'($urandom);
            end
        endcase
        if ($urandom_range(1)) begin
            tmp       = first_op;
            first_op  = second_op;
            second_op = tmp;
        end
    endtask

    task automatic send_random(input int count);
        logic [15:0] first_op;
        logic [15:0] second_op;
        repeat (count) begin
            pick_operands(first_op, second_op);
            send_operands(first_op, second_op);
        end
    endtask

    // Zero operands, field extremes, coprime and shared-factor pairs
    task automatic test_directed();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_operands(16'd0, 16'd0);
        send_operands(16'd0, 16'hFFFF);
        send_operands(16'hFFFF, 16'd0);
        send_operands(16'd1, 16'd1);
        send_operands(16'hFFFF, 16'hFFFF);
        send_operands(16'hFFFF, 16'hFFFE);
        send_operands(16'hFFFE, 16'hFFFF);
        send_operands(16'd1, 16'hFFFF);
        send_operands(16'hFFFF, 16'd1);
        send_operands(16'h8000, 16'h8000);
        send_operands(16'h8000, 16'd1);
        send_operands(16'd2, 16'h8000);
        send_operands(16'd65521, 16'd65519);
        send_operands(16'd12, 16'd18);
        send_operands(16'd48, 16'd180);
        send_operands(16'd7, 16'd7);
        send_operands(16'hAAAA, 16'h5555);
        send_operands(16'h5555, 16'hAAAA);
        send_operands(16'hFFFF, 16'd3);
        send_operands(16'h0001, 16'h0000);
        wait_drained();
    endtask

    // Back-to-back words with both sides always ready
    task automatic test_streaming();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random(400);
        wait_drained();
    endtask

    // Random gaps on both sides
    task automatic test_random_idle();
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
        send_random(900);
        wait_drained();
    endtask

    // Receiver stalls long enough that the output register and core fill up
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = IDLE_PCT;
        rx_hold_req = 1'b1;
        send_random(30);
        wait_drained();
        rx_hold_req = 1'b1;
        tx_idle_pct = IDLE_PCT;
        send_random(200);
        wait_drained();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_streaming();
        test_random_idle();
        test_backpressure();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && lcm_expected.size() == 0) begin
            $display("lcm_unit_top_tb: done, clean");
        end else begin
            $display("lcm_unit_top_tb: done, errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lcmu_pkg.sv
rtl/lcmu_core.sv
rtl/lcm_unit_top.sv
test/lcm_unit_top_tb.sv
